// ----- rtl/core/assert_macros.svh -----
// Assertion macros for RTL that checks its own behaviour; the top level includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DWL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dawg lookup assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define DWL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dawg lookup assertion failed");

// Condition must never be true.
`define DWL_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("dawg lookup assertion failed");

`endif

// ----- rtl/core/dwl_pkg.sv -----
// Types and constants shared by the DAWG word lookup block.
`default_nettype none

package dwl_pkg;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // One edge entry, packed as letter in the low byte, then the two end bits,
  // then the child index.
  typedef struct packed {
    logic [11:0] child;
    logic        node_end;
    logic        word_end;
    logic [7:0]  letter;
  } edge_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_EMIT
  } state_t;

  // Result handed from the controller to the output register.
  typedef struct packed {
    logic valid;
    logic found;
  } res_t;

endpackage

`default_nettype wire

// ----- rtl/core/dwl_edge_ram.sv -----
// Edge store: single write port, single registered read port.
`default_nettype none

module dwl_edge_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  wire logic            clk,
  input  wire logic            we,
  input  wire logic [AW-1:0]   waddr,
  input  wire dwl_pkg::edge_t  wdata,
  input  wire logic            re,
  input  wire logic [AW-1:0]   raddr,
  output dwl_pkg::edge_t       rdata
);

  dwl_pkg::edge_t mem [DEPTH];
  dwl_pkg::edge_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- rtl/core/dwl_scan_ctrl.sv -----
// Lookup controller: cursor, word flags and the sibling scan sequencer.
`default_nettype none

module dwl_scan_ctrl #(
  parameter int EDGE_DEPTH = 4096,
  parameter int AW         = 12
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic          in_op,
  input  wire logic [11:0]   in_edge_index,
  input  wire logic [7:0]    in_edge_letter,
  input  wire logic          in_edge_word_end,
  input  wire logic          in_edge_node_end,
  input  wire logic [11:0]   in_edge_child,
  input  wire logic [7:0]    in_symbol,
  input  wire logic          in_word_last,
  output logic               in_stall,
  input  wire logic          out_free,
  output dwl_pkg::res_t      res,
  output logic               mem_we,
  output logic [AW-1:0]      mem_waddr,
  output dwl_pkg::edge_t     mem_wdata,
  output logic               mem_re,
  output logic [AW-1:0]      mem_raddr,
  input  wire dwl_pkg::edge_t mem_rdata
);

  // Cursor width: holds any child index and the value one past the table.
  localparam int CW = (AW + 1 > 12) ? AW + 1 : 12;
  localparam logic [CW-1:0] DEPTH_C = CW'(EDGE_DEPTH);

  dwl_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]   cursor_r, cursor_nxt;
  logic            miss_r, miss_nxt;
  logic            wes_r, wes_nxt;
  logic [7:0]      sym_r, sym_nxt;
  logic            last_r, last_nxt;
  logic            found_r, found_nxt;

  logic            accept;
  logic            cur_ok;
  logic [CW-1:0]   step;
  logic            step_ok;
  logic [CW-1:0]   idx_ext;
  logic            start;
  logic            done;
  logic            last_now;
  logic            miss_after;
  logic            wes_after;

  assign accept  = in_valid && !in_stall;
  assign cur_ok  = (cursor_r != '0) && (cursor_r < DEPTH_C);
  assign step    = cursor_r + CW'(1);
  assign step_ok = step < DEPTH_C;
  assign idx_ext = CW'(in_edge_index);

  // Datapath: character completion and flag updates.
  always_comb begin
    start      = 1'b0;
    done       = 1'b0;
    last_now   = last_r;
    miss_after = miss_r;
    wes_after  = wes_r;
    cursor_nxt = cursor_r;
    miss_nxt   = miss_r;
    wes_nxt    = wes_r;
    sym_nxt    = sym_r;
    last_nxt   = last_r;
    found_nxt  = found_r;

    case (state_r)
      dwl_pkg::S_IDLE: begin
        if (accept && in_op == dwl_pkg::OP_LOOKUP) begin
          last_now = in_word_last;
          sym_nxt  = in_symbol;
          last_nxt = in_word_last;
          if (miss_r || !cur_ok) begin
            done       = 1'b1;
            miss_after = 1'b1;
          end else begin
            start = 1'b1;
          end
        end
      end
      dwl_pkg::S_CHECK: begin
        if (mem_rdata.letter == sym_r) begin
          done       = 1'b1;
          miss_after = 1'b0;
          wes_after  = mem_rdata.word_end;
          cursor_nxt = CW'(mem_rdata.child);
        end else if (mem_rdata.node_end || !step_ok) begin
          done       = 1'b1;
          miss_after = 1'b1;
        end else begin
          cursor_nxt = step;
        end
      end
      default: begin
      end
    endcase

    if (done) begin
      if (last_now) begin
        found_nxt  = !miss_after && wes_after;
        cursor_nxt = CW'(1);
        miss_nxt   = 1'b0;
        wes_nxt    = 1'b0;
      end else begin
        miss_nxt = miss_after;
        wes_nxt  = wes_after;
      end
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dwl_pkg::S_IDLE: begin
        if (start) begin
          state_nxt = dwl_pkg::S_CHECK;
        end else if (done && last_now) begin
          state_nxt = dwl_pkg::S_EMIT;
        end
      end
      dwl_pkg::S_CHECK: begin
        if (done) begin
          state_nxt = last_now ? dwl_pkg::S_EMIT : dwl_pkg::S_IDLE;
        end
      end
      dwl_pkg::S_EMIT: begin
        if (out_free) begin
          state_nxt = dwl_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = dwl_pkg::S_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    in_stall  = (state_r != dwl_pkg::S_IDLE);
    res.valid = (state_r == dwl_pkg::S_EMIT) && out_free;
    res.found = found_r;

    mem_we    = accept && (in_op == dwl_pkg::OP_WRITE) && (idx_ext < DEPTH_C);
    mem_waddr = idx_ext[AW-1:0];
    mem_wdata.letter   = in_edge_letter;
    mem_wdata.word_end = in_edge_word_end;
    mem_wdata.node_end = in_edge_node_end;
    mem_wdata.child    = in_edge_child;

    mem_re    = 1'b0;
    mem_raddr = cursor_r[AW-1:0];
    case (state_r)
      dwl_pkg::S_IDLE: begin
        mem_re = start;
      end
      dwl_pkg::S_CHECK: begin
        mem_re    = !done;
        mem_raddr = step[AW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= dwl_pkg::S_IDLE;
      cursor_r <= CW'(1);
      miss_r   <= 1'b0;
      wes_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cursor_r <= cursor_nxt;
      miss_r   <= miss_nxt;
      wes_r    <= wes_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sym_r   <= sym_nxt;
    last_r  <= last_nxt;
    found_r <= found_nxt;
  end

endmodule

`default_nettype wire

// ----- rtl/core/dawg_word_lookup.sv -----
// Top level of the DAWG word lookup block: edge store, scan controller, result register.
`default_nettype none

// DAWG word lookup. A request with op 0 writes one edge into the edge store;
// writes to an index at or beyond EDGE_DEPTH are dropped. A request with op 1
// brings one character of a word: the block accepts it and then examines one
// sibling edge at a time, since every edge is fetched through the single read
// port of the edge store, whose read data is registered. A character occupies
// the block until its scan ends (at most the node's size, 256 siblings for a
// full byte alphabet); a character that follows a miss, or that starts at a
// null cursor, is settled as it is accepted, without a read. The last character
// of a word then waits in an emit state until the output register is free and
// hands its result over; that register can hold one result while the next
// request is already being taken. Only the last character of a word yields a
// result. The store is not cleared after reset: every entry must be written
// before a lookup can reach it, and the block is ready as soon as reset ends.

module dawg_word_lookup #(
  parameter int EDGE_DEPTH = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_op,
  input  wire logic [11:0] in_edge_index,
  input  wire logic [7:0]  in_edge_letter,
  input  wire logic        in_edge_word_end,
  input  wire logic        in_edge_node_end,
  input  wire logic [11:0] in_edge_child,
  input  wire logic [7:0]  in_symbol,
  input  wire logic        in_word_last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_found
);

  localparam int AW = $clog2(EDGE_DEPTH);

  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  dwl_pkg::edge_t mem_wdata;
  logic           mem_re;
  logic [AW-1:0]  mem_raddr;
  dwl_pkg::edge_t mem_rdata;
  dwl_pkg::res_t  res;
  logic           out_free;
  logic           out_valid_r;
  logic           out_found_r;

  // Writes happen only while the controller is idle and reads are only issued
  // from a lookup or during a scan, so the two ports never meet on one cycle and
  // a read issued right after a write already sees the new entry.
  dwl_edge_ram #(
    .DEPTH (EDGE_DEPTH),
    .AW    (AW)
  ) u_edge_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  dwl_scan_ctrl #(
    .EDGE_DEPTH (EDGE_DEPTH),
    .AW         (AW)
  ) u_scan_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_op            (in_op),
    .in_edge_index    (in_edge_index),
    .in_edge_letter   (in_edge_letter),
    .in_edge_word_end (in_edge_word_end),
    .in_edge_node_end (in_edge_node_end),
    .in_edge_child    (in_edge_child),
    .in_symbol        (in_symbol),
    .in_word_last     (in_word_last),
    .in_stall         (in_stall),
    .out_free         (out_free),
    .res              (res),
    .mem_we           (mem_we),
    .mem_waddr        (mem_waddr),
    .mem_wdata        (mem_wdata),
    .mem_re           (mem_re),
    .mem_raddr        (mem_raddr),
    .mem_rdata        (mem_rdata)
  );

  // The output register is free when it is empty or its result leaves now.
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_found_r <= res.found;
    end
  end

  assign out_valid = out_valid_r;
  assign out_found = out_found_r;

`include "assert_macros.svh"

  // A result is only pushed into a free output register.
  `DWL_ASSERT_SAME(a_push_free, clk, rst_n, res.valid, out_free)
  // An accepted edge write leaves the block ready for a request in the next cycle.
  `DWL_ASSERT_NEXT(a_write_one_cycle, clk, rst_n,
    in_valid && !in_stall && in_op == dwl_pkg::OP_WRITE, !in_stall)
  // The edge store is never written and read in the same cycle.
  `DWL_ASSERT_NEVER(a_no_port_clash, clk, rst_n, mem_we && mem_re)

endmodule

`default_nettype wire

// ----- test/dawg_word_lookup_test.sv -----
// Self-checking testbench for the DAWG word lookup block, with its scoreboard class.
module dawg_word_lookup_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH       = 4096;
  // Generous: well above a full-length scan with the longest gaps and stalls on every request.
  localparam int CYCLE_LIMIT = 5000000;
  // Longest scan the stimulus can cause, plus the result hand-off, with room to spare.
  localparam int TAIL_CYCLES = 300;

  // The scoreboard keeps its own copy of the edge store and of the lookup state. Every
  // accepted request is applied to that copy; a request that ends a word queues the
  // expected found flag, which the result monitor then pops and compares.
  class word_scoreboard;
    dwl_pkg::edge_t edges [DEPTH];
    bit          written [DEPTH];
    logic [11:0] cursor;
    bit          missed;
    bit          word_end_seen;
    bit          found_q [$];
    int          errors;

    function new();
      cursor        = 12'd1;
      missed        = 1'b0;
      word_end_seen = 1'b0;
      errors        = 0;
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    // Index of the first never-written entry that a lookup of sym would read, or -1.
    function int unread_entry(logic [7:0] sym);
      int i;
      if (missed) return -1;
      i = cursor;
      while (i != 0 && i < DEPTH) begin
        if (!written[i]) return i;
        if (edges[i].letter == sym || edges[i].node_end) return -1;
        i++;
      end
      return -1;
    endfunction

    function void note_request(logic op, logic [11:0] idx, dwl_pkg::edge_t e,
                               logic [7:0] sym, logic last);
      int i;
      bit hit;
      bit done;
      if (op == dwl_pkg::OP_WRITE) begin
        if (int'(idx) < DEPTH) begin
          edges[idx]   = e;
          written[idx] = 1'b1;
        end
        return;
      end
      if (!missed) begin
        i    = cursor;
        hit  = 1'b0;
        done = 1'b0;
        while (!done && i != 0 && i < DEPTH) begin
          if (edges[i].letter == sym) begin
            hit  = 1'b1;
            done = 1'b1;
          end else if (edges[i].node_end) begin
            done = 1'b1;
          end else begin
            i++;
          end
        end
        if (hit) begin
          word_end_seen = edges[i].word_end;
          cursor        = edges[i].child;
        end else begin
          missed = 1'b1;
        end
      end
      if (last) begin
        found_q.push_back(!missed && word_end_seen);
        cursor        = 12'd1;
        missed        = 1'b0;
        word_end_seen = 1'b0;
      end
    endfunction

    task check_result(logic found);
      bit want;
      if (found_q.size() == 0) begin
        report($sformatf("result found=%b arrived with no word pending", found));
      end else begin
        want = found_q.pop_front();
        if (found !== want)
          report($sformatf("found is %b, expected %b", found, want));
      end
    endtask
  endclass

  logic        clk;
  logic        rst_n            = 1'b0;
  logic        in_valid         = 1'b0;
  logic        in_stall;
  logic        in_op            = 1'b0;
  logic [11:0] in_edge_index    = '0;
  logic [7:0]  in_edge_letter   = '0;
  logic        in_edge_word_end = 1'b0;
  logic        in_edge_node_end = 1'b0;
  logic [11:0] in_edge_child    = '0;
  logic [7:0]  in_symbol        = '0;
  logic        in_word_last     = 1'b0;
  logic        out_valid;
  logic        out_stall        = 1'b0;
  logic        out_found;

  word_scoreboard sb;
  int             requests_accepted = 0;
  int             cycle_count       = 0;
  int             result_hold       = 0;
  // While quiet is set neither side idles, so the block is run back to back.
  bit             quiet             = 1'b0;
  // Letters of the current dictionary are mostly drawn from the first few of the alphabet,
  // so that random words actually match.
  int             alphabet          = 4;

  dawg_word_lookup #(
    .EDGE_DEPTH(DEPTH)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_edge_index    (in_edge_index),
    .in_edge_letter   (in_edge_letter),
    .in_edge_word_end (in_edge_word_end),
    .in_edge_node_end (in_edge_node_end),
    .in_edge_child    (in_edge_child),
    .in_symbol        (in_symbol),
    .in_word_last     (in_word_last),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_found        (out_found)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int draw_wait();
    return quiet ? 0 : int'($urandom_range(0, 11));
  endfunction

  function automatic logic [7:0] pick_letter();
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    return 8'(8'h61 + $urandom_range(0, alphabet - 1));
  endfunction

  // Watchdog: a hung handshake must not stall the regression for ever.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result side. Outputs are sampled at the clock edge, before this edge's updates, so an
  // accepted result is one with valid high and our stall low going into the edge. After
  // each accepted result the receiver draws a random hold-off, which is zero while quiet is set.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(out_found);
      result_hold = draw_wait();
    end
    out_stall <= (result_hold > 0);
    if (result_hold > 0) result_hold--;
  end

  // Presents one request after a random gap and holds it until the block takes it. When
  // there is no gap, valid simply stays high from the previous request.
  task automatic send_request(logic op, logic [11:0] idx, logic [7:0] letter, logic wend,
                              logic nend, logic [11:0] child, logic [7:0] sym,
                              logic last);
    int             gap;
    dwl_pkg::edge_t e;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_op            <= op;
    in_edge_index    <= idx;
    in_edge_letter   <= letter;
    in_edge_word_end <= wend;
    in_edge_node_end <= nend;
    in_edge_child    <= child;
    in_symbol        <= sym;
    in_word_last     <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    e.letter   = letter;
    e.word_end = wend;
    e.node_end = nend;
    e.child    = child;
    sb.note_request(op, idx, e, sym, last);
    requests_accepted++;
  endtask

  // Edge writes carry random values on the lookup fields, which the block must ignore.
  task automatic send_edge(int idx, logic [7:0] letter, logic wend, logic nend, int child);
    send_request(dwl_pkg::OP_WRITE, 12'(idx), letter, wend, nend, 12'(child),
                 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  // A lookup character. Entries that were never written must not be read, so any such
  // entry on the scan path is first written as the closing edge of its node.
  task automatic send_symbol(logic [7:0] sym, logic last);
    int u;
    u = sb.unread_entry(sym);
    while (u >= 0) begin
      send_edge(u, pick_letter(), 1'($urandom_range(0, 1)), 1'b1,
                ($urandom_range(0, 1) == 0) ? 0 : int'($urandom_range(1, DEPTH - 1)));
      u = sb.unread_entry(sym);
    end
    send_request(dwl_pkg::OP_LOOKUP, 12'($urandom_range(0, DEPTH - 1)),
                 8'($urandom_range(0, 255)),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 12'($urandom_range(0, DEPTH - 1)), sym, last);
  endtask

  // A write anywhere in the store with every field random; it may well break a node.
  task automatic noise_write();
    send_edge(int'($urandom_range(0, DEPTH - 1)), 8'($urandom_range(0, 255)),
              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
              int'($urandom_range(0, DEPTH - 1)));
  endtask

  // Stop sending until every expected result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.found_q.size() != 0) @(posedge clk);
  endtask

  // Lays out a random dictionary from edge 1 upwards, node by node in breadth-first
  // order. Every node's last sibling closes the node. Some children point back at nodes
  // already placed, which is how a DAWG shares suffixes.
  task automatic build_dictionary();
    int          base_q [$];
    int          size_q [$];
    int          depth_q [$];
    int          head;
    int          next_free;
    int          budget;
    int          j;
    int          sz;
    int          child;
    logic        wend;
    sz     = ($urandom_range(0, 7) == 0) ? int'($urandom_range(20, 64))
                                         : int'($urandom_range(2, 8));
    budget = $urandom_range(30, 150);
    base_q.push_back(1);
    size_q.push_back(sz);
    depth_q.push_back(0);
    next_free = 1 + sz;
    head      = 0;
    while (head < base_q.size()) begin
      for (j = 0; j < size_q[head]; j++) begin
        child = 0;
        if (depth_q[head] < 6 && $urandom_range(0, 9) < 6) begin
          if (base_q.size() > 1 && $urandom_range(0, 4) == 0) begin
            child = base_q[$urandom_range(1, base_q.size() - 1)];
          end else if (next_free < budget) begin
            sz = ($urandom_range(0, 15) == 0) ? int'($urandom_range(10, 40))
                                              : int'($urandom_range(1, 5));
            child = next_free;
            base_q.push_back(next_free);
            size_q.push_back(sz);
            depth_q.push_back(depth_q[head] + 1);
            next_free += sz;
          end
        end
        // Leaves nearly always complete a word; inner edges do so half the time.
        wend = (child == 0) ? ($urandom_range(0, 7) != 0) : 1'($urandom_range(0, 1));
        send_edge(base_q[head] + j, pick_letter(), wend, (j == size_q[head] - 1), child);
      end
      head++;
    end
  endtask

  // Plays one word. A normal word follows the stored graph: at each step it picks one of
  // the siblings reachable from its position, now and then a random byte instead, and it
  // may stop early on an edge that ends a word. A wild word is random bytes throughout.
  task automatic play_word(int max_len, bit wild);
    int         sib [$];
    int         len;
    int         n;
    int         pos;
    int         i;
    int         pick;
    logic [7:0] sym;
    bit         stop;
    len  = $urandom_range(1, max_len);
    pos  = 1;
    stop = 1'b0;
    n    = 0;
    while (!stop) begin
      sib.delete();
      i = pos;
      while (i != 0 && i < DEPTH && sib.size() < 300 && sb.written[i]) begin
        sib.push_back(i);
        if (sb.edges[i].node_end) break;
        i++;
      end
      stop = (n == len - 1);
      if (wild || sib.size() == 0 || $urandom_range(0, 9) == 0) begin
        sym = 8'($urandom_range(0, 255));
        pos = 0;
      end else begin
        pick = sib[$urandom_range(0, sib.size() - 1)];
        sym  = sb.edges[pick].letter;
        pos  = sb.edges[pick].child;
        if (sb.edges[pick].word_end && $urandom_range(0, 2) == 0) stop = 1'b1;
      end
      // Writes in the middle of a word must not upset the lookup under way.
      if ($urandom_range(0, 15) == 0) noise_write();
      send_symbol(sym, stop);
      n++;
    end
  endtask

  // A small hand-built dictionary for the directed part. From edge 1 the root holds 'a',
  // byte 0 and byte 255; 'a' leads on to "ab" and "abc", and byte 255 leads to a node
  // packed against the top of the store whose last entry does not close the node.
  task automatic run_directed();
    send_edge(0, 8'hAA, 1'b1, 1'b1, DEPTH - 1);   // index 0 is never part of a scan
    send_edge(1, "a", 1'b0, 1'b0, 10);
    send_edge(2, 8'h00, 1'b1, 1'b0, 0);
    send_edge(3, 8'hFF, 1'b1, 1'b1, DEPTH - 3);
    send_edge(10, "b", 1'b1, 1'b1, 20);
    send_edge(20, "c", 1'b1, 1'b1, 0);
    send_edge(DEPTH - 3, "x", 1'b0, 1'b0, 0);
    send_edge(DEPTH - 2, "y", 1'b1, 1'b0, DEPTH - 1);
    send_edge(DEPTH - 1, "z", 1'b1, 1'b0, 0);
    // A prefix that is not itself a word.
    send_symbol("a", 1'b0 ^ 1'b1);
    // Walking on from a leaf meets the null edge.
    send_symbol("a", 1'b0);
    send_symbol("b", 1'b0);
    send_symbol("c", 1'b0);
    send_symbol("q", 1'b1);
    // The zero byte as a one-character word.
    send_symbol(8'h00, 1'b1);
    // Byte 255, then up to the last entry of the store.
    send_symbol(8'hFF, 1'b0);
    send_symbol("y", 1'b0);
    send_symbol("z", 1'b1);
    // No match in the top node: the scan runs off the end of the store.
    send_symbol(8'hFF, 1'b0);
    send_symbol("q", 1'b1);
    // An early miss: the later characters are not looked at.
    send_symbol("q", 1'b0);
    send_symbol("a", 1'b0);
    send_symbol("b", 1'b1);
    // The edge under the cursor is rewritten between two characters of a word.
    send_symbol("a", 1'b0);
    send_edge(10, "b", 1'b0, 1'b1, 20);
    send_symbol("b", 1'b1);
  endtask

  initial begin
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    // Let every result of the directed part come home before the random part begins.
    drain();

    // Random part: each phase lays out a fresh dictionary and then plays words against
    // it, mostly well formed, with some random words and stray writes mixed in.
    while (requests_accepted < 1250) begin
      quiet    = ($urandom_range(0, 4) == 0);
      alphabet = $urandom_range(2, 12);
      build_dictionary();
      repeat ($urandom_range(20, 50)) begin
        if (requests_accepted >= 1250) break;
        play_word(7, ($urandom_range(0, 9) == 0));
        if ($urandom_range(0, 11) == 0) noise_write();
      end
      if ($urandom_range(0, 2) == 0) drain();
    end
    quiet = 1'b0;

    // Wind down: wait for the last results, then allow for any scan still running.
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.found_q.size() != 0)
      sb.report($sformatf("%0d words still waiting for a result", sb.found_q.size()));

    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
